// ----- rtl/core/mpsh_pkg.sv -----
// Shared types and constants for the marker pose smoother with hold.
package mpsh_pkg;

    localparam int WEIGHT_W    = 16;
    localparam int HOLD_W      = 8;
    localparam int LOST_W      = 9;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int FRAC_SHIFT  = 16;
    localparam int WEIGHT_REGS = 5;
    localparam int NUM_AXES    = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT0   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD      = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ALWAYS    = 8'd6;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd15;

    // Normalized 0.8^k tap weights in Q0.16, newest sample first.
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET [WEIGHT_REGS] = '{
        16'd19496, 16'd15596, 16'd12477, 16'd9982, 16'd7985
    };

    // One frame event handed from the input register to the working units.
    typedef struct packed {
        logic en;
        logic present;
    } t_step;

endpackage

// ----- rtl/core/mpsh_filter.sv -----
// Position history and weighted-sum smoothing filter with rounding and saturation.
module mpsh_filter #(
    parameter int TAPS        = 5,
    parameter int COORD_WIDTH = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mpsh_pkg::t_step                        i_step,
    input  logic signed [COORD_WIDTH-1:0]          i_pos    [mpsh_pkg::NUM_AXES],
    input  logic [mpsh_pkg::WEIGHT_W-1:0]          i_weight [TAPS],
    output logic signed [COORD_WIDTH-1:0]          o_smooth [mpsh_pkg::NUM_AXES]
);

    localparam int PROD_W = COORD_WIDTH + mpsh_pkg::WEIGHT_W + 1;
    localparam int SUM_W  = PROD_W + $clog2(TAPS);
    localparam int Q_W    = SUM_W - mpsh_pkg::FRAC_SHIFT;

    localparam logic signed [SUM_W-1:0] ROUND_BIAS =
        SUM_W'(1) <<< (mpsh_pkg::FRAC_SHIFT - 1);
    localparam logic signed [Q_W-1:0] Q_MAX =
        {{(Q_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN =
        {{(Q_W - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};

    logic signed [COORD_WIDTH-1:0] r_hist   [TAPS][mpsh_pkg::NUM_AXES];
    logic signed [COORD_WIDTH-1:0] n_hist   [TAPS][mpsh_pkg::NUM_AXES];
    logic signed [COORD_WIDTH-1:0] r_smooth [mpsh_pkg::NUM_AXES];
    logic signed [COORD_WIDTH-1:0] n_smooth [mpsh_pkg::NUM_AXES];
    logic signed [PROD_W-1:0]      prod     [TAPS][mpsh_pkg::NUM_AXES];
    logic signed [SUM_W-1:0]       acc      [mpsh_pkg::NUM_AXES];
    logic signed [Q_W-1:0]         rounded  [mpsh_pkg::NUM_AXES];

    // The new sample enters at tap 0 and the oldest one drops out.
    always_comb begin
        for (int c = 0; c < mpsh_pkg::NUM_AXES; c++) begin
            n_hist[0][c] = i_pos[c];
            for (int k = 1; k < TAPS; k++) begin
                n_hist[k][c] = r_hist[k-1][c];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < mpsh_pkg::NUM_AXES; c++) begin
            acc[c] = '0;
            for (int k = 0; k < TAPS; k++) begin
                prod[k][c] = PROD_W'(n_hist[k][c]) *
                             PROD_W'($signed({1'b0, i_weight[k]}));
                acc[c]     = acc[c] + SUM_W'(prod[k][c]);
            end
            // Arithmetic shift after the bias gives round half up.
            rounded[c] = Q_W'((acc[c] + ROUND_BIAS) >>> mpsh_pkg::FRAC_SHIFT);
            if (rounded[c] > Q_MAX) begin
                n_smooth[c] = COORD_WIDTH'(Q_MAX);
            end else if (rounded[c] < Q_MIN) begin
                n_smooth[c] = COORD_WIDTH'(Q_MIN);
            end else begin
                n_smooth[c] = COORD_WIDTH'(rounded[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS; k++) begin
                for (int c = 0; c < mpsh_pkg::NUM_AXES; c++) begin
                    r_hist[k][c] <= '0;
                end
            end
            for (int c = 0; c < mpsh_pkg::NUM_AXES; c++) begin
                r_smooth[c] <= '0;
            end
        end else if (i_step.en && i_step.present) begin
            r_hist   <= n_hist;
            r_smooth <= n_smooth;
        end
    end

    assign o_smooth = r_smooth;

endmodule

// ----- rtl/core/mpsh_vis.sv -----
// Visibility flag with a lost-frame hold counter.
module mpsh_vis (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mpsh_pkg::t_step               i_step,
    input  logic [mpsh_pkg::HOLD_W-1:0]   i_hold_frames,
    input  logic                          i_always_visible,
    output logic                          o_visible
);

    logic                         r_visible;
    logic                         n_visible;
    logic [mpsh_pkg::LOST_W-1:0]  r_lost;
    logic [mpsh_pkg::LOST_W-1:0]  n_lost;

    always_comb begin
        n_visible = r_visible;
        n_lost    = r_lost;
        if (i_step.present) begin
            n_visible = 1'b1;
            n_lost    = '0;
        end else if (!i_always_visible) begin
            // The counter stops once the hold has expired, so it never wraps.
            if (r_lost > mpsh_pkg::LOST_W'(i_hold_frames)) begin
                n_visible = 1'b0;
            end else begin
                n_lost = r_lost + mpsh_pkg::LOST_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visible <= 1'b0;
            r_lost    <= '0;
        end else if (i_step.en) begin
            r_visible <= n_visible;
            r_lost    <= n_lost;
        end
    end

    assign o_visible = r_visible;

endmodule

// ----- rtl/core/marker_pose_smoother_with_hold.sv -----
// Top level of the marker pose smoother: configuration, handshake and output stage.
//
//  Channel  | Direction | Payload
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tdata: pos_x, pos_y, pos_z; tuser: marker_present
//  m_axis   | out       | tdata: smooth_x, smooth_y, smooth_z; tuser: is_visible
//  cfg      | in        | index: register number; data: register value
//
// One transaction per clock is sustained while the output is not stalled; a
// frame event passes from acceptance into the input register and then through
// the multiply-accumulate into the result register. Reset is synchronous and
// clears history, result, visibility and weights to their defaults. A stalled
// output holds the pipeline, and the input side keeps accepting while the
// input register can drain into the result register.
module marker_pose_smoother_with_hold #(
    parameter int TAPS        = 5,
    parameter int COORD_WIDTH = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // Bits from low: pos_x, pos_y, pos_z, zero fill.
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]    i_s_axis_tdata,
    // Bits from low: marker_present.
    input  logic [0:0]                            i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // Bits from low: smooth_x, smooth_y, smooth_z, zero fill.
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]    o_m_axis_tdata,
    // Bits from low: is_visible.
    output logic [0:0]                            o_m_axis_tuser,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mpsh_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [mpsh_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int DATA_W = ((3*COORD_WIDTH+7)/8)*8;
    localparam int PAD_W  = DATA_W - 3*COORD_WIDTH;

    logic                               r_s1_valid;
    logic                               r_s1_present;
    logic signed [COORD_WIDTH-1:0]      r_s1_pos [mpsh_pkg::NUM_AXES];
    logic                               r_out_valid;
    logic                               advance;
    logic                               cfg_write;
    mpsh_pkg::t_step                    step;
    logic [mpsh_pkg::WEIGHT_W-1:0]      weight [TAPS];
    logic [mpsh_pkg::HOLD_W-1:0]        r_hold_frames;
    logic                               r_always_visible;
    logic signed [COORD_WIDTH-1:0]      smooth [mpsh_pkg::NUM_AXES];
    logic                               visible;

    // ---------------- configuration registers ----------------
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid;

    for (genvar k = 0; k < TAPS; k++) begin : g_weight
        if (k < mpsh_pkg::WEIGHT_REGS) begin : g_reg
            logic [mpsh_pkg::WEIGHT_W-1:0] r_weight;
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_weight <= mpsh_pkg::WEIGHT_RESET[k];
                end else if (cfg_write &&
                             i_cfg_index == mpsh_pkg::REG_WEIGHT0 +
                                            mpsh_pkg::CFG_INDEX_W'(k)) begin
                    r_weight <= i_cfg_data;
                end
            end
            assign weight[k] = r_weight;
        end else begin : g_zero
            // Taps past the weight registers carry no weight.
            assign weight[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_frames    <= mpsh_pkg::HOLD_RESET;
            r_always_visible <= 1'b0;
        end else if (cfg_write) begin
            if (i_cfg_index == mpsh_pkg::REG_HOLD) begin
                r_hold_frames <= i_cfg_data[mpsh_pkg::HOLD_W-1:0];
            end
            if (i_cfg_index == mpsh_pkg::REG_ALWAYS) begin
                r_always_visible <= i_cfg_data[0];
            end
        end
    end

    // ---------------- input register and flow control ----------------
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_s1_present <= i_s_axis_tuser[0];
            for (int c = 0; c < mpsh_pkg::NUM_AXES; c++) begin
                r_s1_pos[c] <= i_s_axis_tdata[c*COORD_WIDTH +: COORD_WIDTH];
            end
        end
    end

    assign step.en      = r_s1_valid && advance;
    assign step.present = r_s1_present;

    // ---------------- working units ----------------
    mpsh_filter #(
        .TAPS        (TAPS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_filter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_pos    (r_s1_pos),
        .i_weight (weight),
        .o_smooth (smooth)
    );

    mpsh_vis u_vis (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_hold_frames    (r_hold_frames),
        .i_always_visible (r_always_visible),
        .o_visible        (visible)
    );

    // ---------------- result register ----------------
    // The filter and visibility state registers double as the result payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = visible;

    if (PAD_W > 0) begin : g_pad
        assign o_m_axis_tdata = {{PAD_W{1'b0}}, smooth[2], smooth[1], smooth[0]};
    end else begin : g_nopad
        assign o_m_axis_tdata = {smooth[2], smooth[1], smooth[0]};
    end

    // ---------------- assertions ----------------
    a_seen_sets_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step.en && step.present |=> o_m_axis_tuser[0])
        else $error("visible flag not set after a seen frame");

    a_drain_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step.en |=> r_out_valid)
        else $error("processed transaction did not reach the output register");

    a_always_visible_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step.en && !step.present && r_always_visible |=>
            $stable(o_m_axis_tuser) && $stable(o_m_axis_tdata))
        else $error("lost frame changed output in always-visible mode");

    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_s_axis_tready)
        else $error("input stalled with an empty output register");

endmodule
